// ===== rtl/core/decsig_pkg.sv =====
// shared constants and types of the decimating sigma combiner
package decsig_pkg;

  localparam int OUT_W     = 21;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 16;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_WEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] DECIMATION_RST = 16'd1;
  localparam logic [CFG_W-1:0] SIG_WEIGHT_RST = 16'd256;

  typedef struct packed {
    logic [CFG_W-1:0] decimation;
    logic [CFG_W-1:0] sig_weight;
  } cfg_t;

endpackage

// ===== rtl/core/decsig_queue.sv =====
// two-entry queue between the front and back ends
module decsig_queue #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              wr_ptr_nxt;
  logic              rd_ptr_r;
  logic              rd_ptr_nxt;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/decsig_front.sv =====
// input side: sample counter that keeps one beat in every decimation beats
module decsig_front #(
  parameter int DATA_W = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  decsig_pkg::cfg_t    cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DATA_W-1:0]   in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [DATA_W-1:0]   push_data
);

  logic [decsig_pkg::CNT_W-1:0] count_r;
  logic [decsig_pkg::CNT_W-1:0] count_nxt;
  logic [decsig_pkg::CNT_W-1:0] count_inc;
  logic                         keep;
  logic                         accept;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign count_inc  = count_r + decsig_pkg::CNT_W'(1);
  assign keep       = !(count_inc < cfg.decimation);
  assign push_valid = in_valid && keep;
  assign push_data  = in_data;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = keep ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/decsig_back.sv =====
// result side: moment arithmetic, bit-serial square root and output register
module decsig_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  decsig_pkg::cfg_t              cfg,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [4*SAMPLE_BITS-1:0]      pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [decsig_pkg::OUT_W-1:0]  out_sigma_out
);

  localparam int SB     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SB;
  localparam int PP_W   = SB + decsig_pkg::CFG_W;
  localparam int WIDE_W = 2 * SB + 17;
  localparam int SUM_W  = (2 * SB + 15 > 64) ? 64 : 2 * SB + 15;
  localparam int X_W    = SUM_W - decsig_pkg::FRAC_BITS;
  localparam int RW     = X_W + 1;
  localparam int ROOT_W = (X_W + 1) / 2;
  localparam int IT_W   = $clog2(ROOT_W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_SCALE  = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_ROOT   = 3'd4;
  localparam logic [2:0] S_HOLD   = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [SQ_W-1:0]   msq_r;
  logic [SB-1:0]     mv_r;
  logic [SB-1:0]     sg_r;
  logic [SQ_W-1:0]   mv2_r;
  logic [SQ_W-1:0]   sg2_r;
  logic [SQ_W-1:0]   diff_r;
  logic [PP_W-1:0]   plo_r;
  logic [PP_W-1:0]   phi_r;
  logic [RW-1:0]     x_r;
  logic [RW-1:0]     x_nxt;
  logic [RW-1:0]     root_r;
  logic [RW-1:0]     root_nxt;
  logic [RW-1:0]     bit_r;
  logic [IT_W-1:0]   iter_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [decsig_pkg::OUT_W-1:0] out_r;

  logic [SB-1:0]     raw_mv;
  logic [SB-1:0]     raw_sg;
  logic [SB-1:0]     mag_mv;
  logic [SB-1:0]     mag_sg;
  logic [WIDE_W-1:0] wide_sum;
  logic [SUM_W-1:0]  sum;
  logic [RW-1:0]     trial;
  logic              slot_free;
  logic              load_out;

  assign raw_mv = pop_data[2*SB-1:SB];
  assign raw_sg = pop_data[SB-1:0];
  assign mag_mv = raw_mv[SB-1] ? (~raw_mv + SB'(1)) : raw_mv;
  assign mag_sg = raw_sg[SB-1] ? (~raw_sg + SB'(1)) : raw_sg;

  assign pop_ready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (state_r == S_HOLD) && slot_free;

  assign wide_sum = WIDE_W'({diff_r, {decsig_pkg::FRAC_BITS{1'b0}}})
                  + WIDE_W'(plo_r) + (WIDE_W'(phi_r) << SB);
  assign sum      = wide_sum[SUM_W-1:0];
  assign trial    = root_r + bit_r;

  always_comb begin
    x_nxt    = x_r;
    root_nxt = root_r >> 1;
    if (x_r >= trial) begin
      x_nxt    = x_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (pop_valid) state_nxt = S_SQUARE;
      S_SQUARE: state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ROOT;
      S_ROOT:   if (iter_r == '0) state_nxt = S_HOLD;
      S_HOLD:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          msq_r <= pop_data[4*SB-1:2*SB];
          mv_r  <= mag_mv;
          sg_r  <= mag_sg;
        end
      end
      S_SQUARE: begin
        mv2_r <= SQ_W'(mv_r * mv_r);
        sg2_r <= SQ_W'(sg_r * sg_r);
      end
      S_SCALE: begin
        diff_r <= (msq_r >= mv2_r) ? (msq_r - mv2_r) : (mv2_r - msq_r);
        plo_r  <= PP_W'(cfg.sig_weight * sg2_r[SB-1:0]);
        phi_r  <= PP_W'(cfg.sig_weight * sg2_r[SQ_W-1:SB]);
      end
      S_SUM: begin
        x_r    <= RW'(sum[SUM_W-1:decsig_pkg::FRAC_BITS]);
        root_r <= '0;
        bit_r  <= RW'(1) << (2 * (ROOT_W - 1));
        iter_r <= IT_W'(ROOT_W - 1);
      end
      S_ROOT: begin
        x_r    <= x_nxt;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        iter_r <= iter_r - IT_W'(1);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_r <= decsig_pkg::OUT_W'(root_r[ROOT_W-1:0]);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sigma_out = out_r;

endmodule

// ===== rtl/core/decimating_sigma_combiner.sv =====
// top level of the decimating sigma combiner
//
// input channel (in_valid/in_ready): one beat carries mean square, mean and
// extra sigma. a sample counter keeps one beat in every decimation beats;
// dropped beats give no result and are taken one per cycle while the queue has room.
// kept beats go through a two-entry queue to the back end, which squares,
// weights, sums and takes a floor square root one result bit per cycle.
// result channel (out_valid/out_ready): sigma_out = isqrt of
// (256*|msq - mean^2| + weight*sigma^2) / 256, held in an output register.
// a kept beat goes through the square, scale, sum, root and hold states to
// out_valid. the back end takes a new kept beat only from idle, after the
// bit-serial root loop and the output load for the last one; the front end
// keeps accepting while the queue has room.
// configuration: cfg_wr_en with cfg_index 0 writes decimation, 1 writes the
// sigma weight; write only while the block is idle.
// reset: synchronous active-low rst_n clears the counter, queue, sequencer and
// output valid; decimation returns to 1 and the sigma weight to 1.0.
// when out_ready is low the result is held, the back end stalls after its next
// result and the queue then fills, which drops in_ready.
module decimating_sigma_combiner #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [decsig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [decsig_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2*SAMPLE_BITS-1:0]             in_mean_square,
  input  logic signed [SAMPLE_BITS-1:0]        in_mean_value,
  input  logic signed [SAMPLE_BITS-1:0]        in_extra_sigma,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [decsig_pkg::OUT_W-1:0]         out_sigma_out
);

  localparam int DATA_W = 4 * SAMPLE_BITS;

  decsig_pkg::cfg_t cfg_r;
  decsig_pkg::cfg_t cfg_nxt;

  logic [DATA_W-1:0] in_data;
  logic              push_valid;
  logic              push_ready;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [DATA_W-1:0] pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      if (cfg_index == decsig_pkg::CFG_DECIMATION) begin
        cfg_nxt.decimation = cfg_data;
      end else if (cfg_index == decsig_pkg::CFG_SIG_WEIGHT) begin
        cfg_nxt.sig_weight = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decimation <= decsig_pkg::DECIMATION_RST;
      cfg_r.sig_weight <= decsig_pkg::SIG_WEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_data = {in_mean_square, in_mean_value, in_extra_sigma};

  decsig_front #(
    .DATA_W (DATA_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  decsig_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  decsig_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sigma_out (out_sigma_out)
  );

endmodule
